>>> hdl/float_pair_to_half_packer_defines.svh
// Assertion macros shared by the checker.
`ifndef FLOAT_PAIR_TO_HALF_PACKER_DEFINES_SVH
`define FLOAT_PAIR_TO_HALF_PACKER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FPH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fph_pkg.sv
`timescale 1ns / 1ps
package fph_pkg;

  localparam int unsigned SglW  = 32;
  localparam int unsigned HalfW = 16;

  localparam logic [15:0] HalfExpAllOnes = 16'h7c00;
  localparam logic [15:0] HalfSignBit    = 16'h8000;
  localparam logic [7:0]  ExpRebias      = 8'd112;
  localparam logic [7:0]  ExpSpecial     = 8'd255;
  // Biased single exponents bounding the half ranges.
  localparam logic [7:0]  ExpSubMin      = 8'd102;  // half exponent -10
  localparam logic [7:0]  ExpNormMin     = 8'd113;  // half exponent 1
  localparam logic [5:0]  HalfExpMax     = 6'd30;

  typedef logic [SglW-1:0]  sgl_t;
  typedef logic [HalfW-1:0] half_t;

endpackage

>>> hdl/fph_stream_if.sv
`timescale 1ns / 1ps
interface fph_stream_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/fph_pair_if.sv
`timescale 1ns / 1ps
interface fph_pair_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_value_bits;
  logic [31:0] second_value_bits;

  modport source (output valid, output first_value_bits, output second_value_bits,
                  input ready);
  modport sink   (input valid, input first_value_bits, input second_value_bits,
                  output ready);
endinterface

>>> hdl/fph_lane.sv
`timescale 1ns / 1ps
module fph_lane (
  input  fph_pkg::sgl_t  sgl_i,
  output fph_pkg::half_t half_o
);

  logic        sign;
  logic [7:0]  exp_s;
  logic [22:0] mant;
  logic [23:0] sig;
  logic [3:0]  shamt;
  logic [23:0] sub_shift;
  logic [10:0] sub_rnd;
  logic [10:0] norm_rnd;
  logic [7:0]  exp_h;
  logic [7:0]  exp_r;
  logic [9:0]  nan_m;

  always_comb begin
    sign      = sgl_i[31];
    exp_s     = sgl_i[30:23];
    mant      = sgl_i[22:0];
    sig       = {1'b1, mant};
    shamt     = 4'(fph_pkg::ExpNormMin - exp_s);
    sub_shift = sig >> shamt;
    // The carry from rounding moves naturally into the exponent field.
    sub_rnd   = {1'b0, sub_shift[22:13]} + {10'd0, sub_shift[12]};
    norm_rnd  = {1'b0, mant[22:13]} + {10'd0, mant[12]};
    // Kept at full width so that large exponents still register as overflow.
    exp_h     = exp_s - fph_pkg::ExpRebias;
    exp_r     = exp_h + {7'd0, norm_rnd[10]};
    nan_m     = (mant[22:13] == 10'd0) ? 10'd1 : mant[22:13];

    if (exp_s < fph_pkg::ExpSubMin) begin
      half_o = {sign, 15'd0};
    end else if (exp_s < fph_pkg::ExpNormMin) begin
      half_o = {sign, 4'd0, sub_rnd};
    end else if (exp_s == fph_pkg::ExpSpecial) begin
      half_o = (mant == 23'd0) ? ({sign, 15'd0} | fph_pkg::HalfExpAllOnes)
                               : ({sign, 5'h1f, nan_m});
    end else if (exp_r > {2'd0, fph_pkg::HalfExpMax}) begin
      half_o = {sign, 15'd0} | fph_pkg::HalfExpAllOnes;
    end else begin
      half_o = {sign, exp_r[4:0], norm_rnd[9:0]};
    end
  end

endmodule

>>> hdl/float_pair_to_half_packer.sv
`timescale 1ns / 1ps
// Result: an accepted request's result appears at the output register in the next cycle.
// Throughput: one request per cycle unless the output stalls; a new request is taken
// while the held result is being taken, so the single output register sets the rate.
// Reset: rst_ni clears the output valid flag asynchronously; data needs no reset.
module float_pair_to_half_packer (
  input  logic          clk_i,
  input  logic          rst_ni,
  fph_pair_if.sink      in_if,
  fph_stream_if.source  out_if
);

  // Two identical conversion lanes, one per value in the request.
  fph_pkg::half_t lo_half;
  fph_pkg::half_t hi_half;

  fph_lane u_lane_lo (.sgl_i(in_if.first_value_bits),  .half_o(lo_half));
  fph_lane u_lane_hi (.sgl_i(in_if.second_value_bits), .half_o(hi_half));

  // Merging stage: both halves are joined into one output word.
  logic        valid_q, valid_d;
  logic [31:0] data_q, data_d;
  logic        take;

  // The block accepts whenever the output register is empty or being drained.
  assign in_if.ready = !valid_q || out_if.ready;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (in_if.ready) begin
      valid_d = in_if.valid;
    end
    if (take) begin
      data_d = {hi_half, lo_half};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_if.valid = valid_q;
  assign out_if.data  = data_q;

endmodule

>>> hdl/fph_checker.sv
`timescale 1ns / 1ps
`include "float_pair_to_half_packer_defines.svh"
module fph_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_data_i
);

  `FPH_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i, "accepted request produced no result")
  `FPH_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i, "input stalled with empty output")
  `FPH_ASSERT_NEXT(a_hold_stalled, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")

endmodule

bind float_pair_to_half_packer fph_checker u_fph_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for the float pair to half packer.
// Each request carries two single-precision bit patterns. A local converter
// predicts the packed half-precision word (ties rounded up in magnitude), and
// every request that is accepted pushes its prediction onto a queue. A
// separate process samples the output at each rising edge and compares each
// accepted result with the oldest prediction. Both sides draw random waits,
// the receiver holds off once for a long stretch so that the block stalls,
// and the sender pauses once until every prediction has been met.
module testbench;

  localparam int unsigned MaxCycles = 200000;

  logic clk_i;
  logic rst_ni;

  fph_pair_if             in_if ();
  fph_stream_if #(.Width(32)) out_if ();

  float_pair_to_half_packer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  logic [31:0] packed_words_due[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned hold_off_cycles;
  bit          sink_idling_on;

  // Clock with a period of 12 ns.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %08h expected %08h", what, got, want);
    mismatch_count++;
  endtask

  // Converts one single-precision pattern to half precision, rounding half up.
  function automatic fph_pkg::half_t single_to_half(input fph_pkg::sgl_t bits);
    logic [15:0] sign;
    int          ex;
    logic [31:0] mant;
    sign = {bits[31], 15'd0};
    ex   = int'(bits[30:23]) - 112;
    mant = {9'd0, bits[22:0]};
    if (ex <= 0) begin
      if (ex < -10) return sign;
      mant = (mant | 32'h0080_0000) >> (1 - ex);
      if (mant[12]) mant = mant + 32'h2000;
      return sign | mant[28:13];
    end
    if (ex == 143) begin
      if (mant == 32'd0) return sign | fph_pkg::HalfExpAllOnes;
      mant = mant >> 13;
      if (mant == 32'd0) mant = 32'd1;
      return sign | fph_pkg::HalfExpAllOnes | mant[15:0];
    end
    if (mant[12]) begin
      mant = mant + 32'h2000;
      if (mant[23]) begin
        mant = 32'd0;
        ex++;
      end
    end
    if (ex > 30) return sign | fph_pkg::HalfExpAllOnes;
    return sign | (16'(ex) << 10) | mant[28:13];
  endfunction

  // Offers one request after a random gap and waits until it is taken.
  // Valid stays high afterwards so that the next request can follow directly.
  task automatic send_pair(input fph_pkg::sgl_t first_bits,
                           input fph_pkg::sgl_t second_bits);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.first_value_bits  <= first_bits;
    in_if.second_value_bits <= second_bits;
    do @(posedge clk_i); while (!in_if.ready);
    packed_words_due.insert(packed_words_due.size(),
                            {single_to_half(second_bits), single_to_half(first_bits)});
    @(negedge clk_i);
  endtask

  // Withdraws the request line once a run of requests is over.
  task automatic release_input();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Receiver: draws a wait for each result unless idling is switched off, honouring any long hold-off.
  initial begin
    int unsigned wait_cycles;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_off_cycles--;
      end else if (!sink_idling_on) begin
        out_if.ready <= 1'b1;
      end else begin
        wait_cycles = $urandom_range(0, 6);
        if (wait_cycles > 0 && $urandom_range(0, 2) != 0) begin
          out_if.ready <= 1'b0;
          repeat (wait_cycles) @(negedge clk_i);
        end
        out_if.ready <= 1'b1;
        @(posedge clk_i);
        while (!out_if.valid && hold_off_cycles == 0) @(posedge clk_i);
      end
    end
  end

  // Checks each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (packed_words_due.size() == 0) begin
        report_mismatch("unexpected result", out_if.data, 32'd0);
      end else begin
        logic [31:0] want;
        want = packed_words_due.pop_front();
        if (out_if.data[15:0] !== want[15:0])
          report_mismatch("low half", out_if.data, want);
        if (out_if.data[31:16] !== want[31:16])
          report_mismatch("high half", out_if.data, want);
      end
    end
  end

  // Random single pattern that lands near the half range most of the time.
  function automatic fph_pkg::sgl_t random_single();
    fph_pkg::sgl_t bits;
    bits = $urandom;
    case ($urandom_range(0, 5))
      0, 1, 2: bits[30:23] = 8'($urandom_range(100, 145));
      3:       bits[30:23] = 8'($urandom_range(0, 1)) ? 8'd255 : 8'd0;
      4:       bits[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
      default: ;
    endcase
    return bits;
  endfunction

  task automatic test_directed_cases();
    fph_pkg::sgl_t cases[$];
    cases = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
              32'h3300_0000, 32'h3300_0001, 32'h32ff_ffff, 32'h3880_0000,
              32'h387f_f000, 32'h387f_efff, 32'h477f_e000, 32'h477f_f000,
              32'hc77f_efff, 32'h4780_0000, 32'h7f80_0000, 32'hff80_0000,
              32'h7fc0_0000, 32'hff80_0001, 32'h7fff_ffff, 32'h0000_0001,
              32'h3f80_1000, 32'h3f80_0fff, 32'hffff_ffff, 32'h5555_5555};
    foreach (cases[i]) send_pair(cases[i], cases[cases.size() - 1 - i]);
    release_input();
  endtask

  task automatic test_random_pairs(input int unsigned count);
    repeat (count) send_pair(random_single(), random_single());
    release_input();
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_output_stall();
    hold_off_cycles = 60;
    repeat (20) send_pair(random_single(), random_single());
    release_input();
  endtask

  // The sender waits until every prediction has been met.
  task automatic test_drain_pause();
    while (packed_words_due.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic test_back_to_back();
    sink_idling_on = 1'b0;
    repeat (150) begin
      in_if.valid             <= 1'b1;
      in_if.first_value_bits  <= random_single();
      in_if.second_value_bits <= random_single();
      do @(posedge clk_i); while (!in_if.ready);
      packed_words_due.insert(packed_words_due.size(),
                              {single_to_half(in_if.second_value_bits),
                               single_to_half(in_if.first_value_bits)});
      @(negedge clk_i);
    end
    release_input();
    sink_idling_on = 1'b1;
  endtask

  initial begin
    int unsigned drain_cycles;
    mismatch_count          = 0;
    cycle_count             = 0;
    hold_off_cycles         = 0;
    sink_idling_on          = 1'b1;
    in_if.valid             = 1'b0;
    in_if.first_value_bits  = '0;
    in_if.second_value_bits = '0;
    rst_ni                  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_pairs(500);
    test_output_stall();
    test_drain_pause();
    test_back_to_back();
    test_random_pairs(530);

    drain_cycles = 0;
    while (packed_words_due.size() != 0 && drain_cycles < 5000) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && packed_words_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/fph_pkg.sv
hdl/fph_stream_if.sv
hdl/fph_pair_if.sv
hdl/fph_lane.sv
hdl/float_pair_to_half_packer.sv
hdl/fph_checker.sv
tb/testbench.sv
